>>> design/bpas_pkg.sv
// shared widths, types and constants for the bezier point splat block
`default_nettype none
package bpas_pkg;

    localparam int COORD_W   = 10;          // pixel coordinate and control point width
    localparam int T_W       = 17;          // curve parameter width
    localparam int POS_W     = 26;          // Q.16 position width
    localparam int MAG_W     = 17;          // offset magnitude width
    localparam int D2_W      = 2 * MAG_W;   // squared distance width
    localparam int ROOT_W    = MAG_W;       // distance width
    localparam int COV_W     = 9;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_REGS  = 8;           // point0_x .. point3_y

    // default image size
    localparam int IMG_W_DEF = 1024;
    localparam int IMG_H_DEF = 1024;

    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    // pixel sideband that rides along the distance pipeline
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_pix_tag;

endpackage
`default_nettype wire

>>> design/bpas_isqrt_pipe.sv
// pipelined integer square root, up to four result bits per stage
`default_nettype none
module bpas_isqrt_pipe (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [bpas_pkg::D2_W-1:0]   i_val,
    input  wire bpas_pkg::t_pix_tag          i_tag,
    output logic                             o_valid,
    output logic [bpas_pkg::ROOT_W-1:0]      o_root,
    output bpas_pkg::t_pix_tag               o_tag
);
    import bpas_pkg::*;

    localparam int NPAIR = D2_W / 2;
    localparam int PPS   = 4;
    localparam int NSTG  = (NPAIR + PPS - 1) / PPS;
    localparam int REM_W = ROOT_W + 4;

    logic                r_v    [NSTG];
    logic [D2_W-1:0]     r_val  [NSTG];
    logic [REM_W-1:0]    r_rem  [NSTG];
    logic [ROOT_W-1:0]   r_root [NSTG];
    t_pix_tag            r_tag  [NSTG];

    genvar g;
    generate
        for (g = 0; g < NSTG; g++) begin : g_stg
            localparam int HI = NPAIR - 1 - PPS * g;
            localparam int LO = (HI - PPS + 1 < 0) ? 0 : HI - PPS + 1;

            logic              s_v;
            logic [D2_W-1:0]   s_val;
            logic [REM_W-1:0]  s_rem;
            logic [ROOT_W-1:0] s_root;
            t_pix_tag          s_tag;
            logic [REM_W-1:0]  n_rem;
            logic [ROOT_W-1:0] n_root;

            if (g == 0) begin : g_first
                assign s_v    = i_valid;
                assign s_val  = i_val;
                assign s_rem  = '0;
                assign s_root = '0;
                assign s_tag  = i_tag;
            end else begin : g_next
                assign s_v    = r_v[g-1];
                assign s_val  = r_val[g-1];
                assign s_rem  = r_rem[g-1];
                assign s_root = r_root[g-1];
                assign s_tag  = r_tag[g-1];
            end

            // restoring square root steps over this stage's bit pairs
            always_comb begin
                logic [REM_W-1:0] trial;
                n_rem  = s_rem;
                n_root = s_root;
                for (int p = HI; p >= LO; p--) begin
                    n_rem = {n_rem[REM_W-3:0], s_val[2*p+1 -: 2]};
                    trial = {2'b00, n_root, 2'b01};
                    if (n_rem >= trial) begin
                        n_rem  = n_rem - trial;
                        n_root = {n_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        n_root = {n_root[ROOT_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= s_v;
                end
                if (i_en) begin
                    r_val[g]  <= s_val;
                    r_rem[g]  <= n_rem;
                    r_root[g] <= n_root;
                    r_tag[g]  <= s_tag;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NSTG-1];
    assign o_root  = r_root[NSTG-1];
    assign o_tag   = r_tag[NSTG-1];

endmodule
`default_nettype wire

>>> design/bezier_point_antialias_splat.sv
// cubic bezier point evaluation with 2x2 anti-aliased pixel splat
//
//  channel   | direction | payload
//  ----------+-----------+--------------------------------------------------
//  s stream  | in        | tdata[16:0] t_value
//  m stream  | out       | tdata[9:0] pixel_x, [19:10] pixel_y, [28:20] coverage,
//            |           | tlast last_pixel
//  cfg write | in        | index 0..7 selects point0_x .. point3_y, data 10 bits
//
// a t value is accepted every cycle while the interpolation pipe has room;
// the pixel serializer then spends one cycle per in-image pixel while the output
// is not stalled, which sets the sustained rate.
// reset is synchronous and clears control state and the control points.
// a stalled output freezes the pixel pipe; the front pipe stops when full.
`default_nettype none
module bezier_point_antialias_splat #(
    parameter int IMAGE_WIDTH  = bpas_pkg::IMG_W_DEF,
    parameter int IMAGE_HEIGHT = bpas_pkg::IMG_H_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [23:0]                     i_s_tdata,   // t_value
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [31:0]                          o_m_tdata,   // pixel_x, pixel_y, coverage
    output logic                                 o_m_tlast,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bpas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bpas_pkg::COORD_W-1:0]    i_cfg_data
);
    import bpas_pkg::*;

    localparam logic signed [13:0] X_LIM = 14'(IMAGE_WIDTH);
    localparam logic signed [13:0] Y_LIM = 14'(IMAGE_HEIGHT);

    // Q.16 lerp: a + round((b - a) * t)
    function automatic logic [POS_W-1:0] lerp_q16(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b,
                                                  input logic [T_W-1:0]   t);
        logic signed [POS_W:0]        d;
        logic signed [POS_W+T_W+1:0]  p;
        logic signed [POS_W+T_W+1:0]  q;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, t});
        q = (p + (POS_W+T_W+2)'(32768)) >>> 16;
        return POS_W'($signed({{(T_W+2){1'b0}}, a}) + q);
    endfunction

    // control point registers
    logic [COORD_W-1:0] r_pt_x [4];
    logic [COORD_W-1:0] r_pt_y [4];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_pt_x[k] <= '0;
                r_pt_y[k] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            if (i_cfg_index[0]) begin
                r_pt_y[i_cfg_index[2:1]] <= i_cfg_data;
            end else begin
                r_pt_x[i_cfg_index[2:1]] <= i_cfg_data;
            end
        end
    end

    // front pipe: t register and three interpolation levels
    logic               r_a0_v, r_a1_v, r_a2_v, r_a3_v;
    logic [T_W-1:0]     r_a0_t, r_a1_t, r_a2_t;
    logic [POS_W-1:0]   r_a1_x [3];
    logic [POS_W-1:0]   r_a1_y [3];
    logic [POS_W-1:0]   r_a2_x [2];
    logic [POS_W-1:0]   r_a2_y [2];
    logic [POS_W-1:0]   r_a3_x, r_a3_y;
    logic               en_a0, en_a1, en_a2, en_a3, take_a;
    logic [T_W-1:0]     in_t;

    assign en_a3      = !r_a3_v || take_a;
    assign en_a2      = !r_a2_v || en_a3;
    assign en_a1      = !r_a1_v || en_a2;
    assign en_a0      = !r_a0_v || en_a1;
    assign o_s_tready = en_a0;
    assign in_t       = (i_s_tdata[T_W-1:0] > T_ONE) ? T_ONE : i_s_tdata[T_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0_v <= 1'b0;
            r_a1_v <= 1'b0;
            r_a2_v <= 1'b0;
            r_a3_v <= 1'b0;
        end else begin
            if (en_a0) r_a0_v <= i_s_tvalid;
            if (en_a1) r_a1_v <= r_a0_v;
            if (en_a2) r_a2_v <= r_a1_v;
            if (en_a3) r_a3_v <= r_a2_v;
        end
        if (en_a0) r_a0_t <= in_t;
        if (en_a1) begin
            r_a1_t <= r_a0_t;
            for (int k = 0; k < 3; k++) begin
                r_a1_x[k] <= lerp_q16({r_pt_x[k], 16'b0}, {r_pt_x[k+1], 16'b0}, r_a0_t);
                r_a1_y[k] <= lerp_q16({r_pt_y[k], 16'b0}, {r_pt_y[k+1], 16'b0}, r_a0_t);
            end
        end
        if (en_a2) begin
            r_a2_t <= r_a1_t;
            for (int k = 0; k < 2; k++) begin
                r_a2_x[k] <= lerp_q16(r_a1_x[k], r_a1_x[k+1], r_a1_t);
                r_a2_y[k] <= lerp_q16(r_a1_y[k], r_a1_y[k+1], r_a1_t);
            end
        end
        if (en_a3) begin
            r_a3_x <= lerp_q16(r_a2_x[0], r_a2_x[1], r_a2_t);
            r_a3_y <= lerp_q16(r_a2_y[0], r_a2_y[1], r_a2_t);
        end
    end

    // neighbourhood start and in-image mask of the finished point
    logic signed [11:0] ld_sx, ld_sy;
    logic [15:0]        ld_dx0, ld_dy0;
    logic [3:0]         ld_mask;
    logic               x0_in, x1_in, y0_in, y1_in;

    always_comb begin
        ld_sx  = $signed({2'b00, r_a3_x[POS_W-1:16]}) - $signed({11'b0, ~r_a3_x[15]});
        ld_sy  = $signed({2'b00, r_a3_y[POS_W-1:16]}) - $signed({11'b0, ~r_a3_y[15]});
        ld_dx0 = {~r_a3_x[15], r_a3_x[14:0]};
        ld_dy0 = {~r_a3_y[15], r_a3_y[14:0]};
        x0_in  = !ld_sx[11] && (14'(ld_sx) < X_LIM);
        x1_in  = (14'(ld_sx) + 14'sd1 < X_LIM);
        y0_in  = !ld_sy[11] && (14'(ld_sy) < Y_LIM);
        y1_in  = (14'(ld_sy) + 14'sd1 < Y_LIM);
        // bit order: {x+1 y+1, x+1 y, x y+1, x y}
        ld_mask = {x1_in && y1_in, x1_in && y0_in, x0_in && y1_in, x0_in && y0_in};
    end

    // pixel serializer, one in-image pixel per cycle while the output is not stalled
    logic               r_s_v;
    logic [3:0]         r_s_rem;
    logic signed [11:0] r_s_sx, r_s_sy;
    logic [15:0]        r_s_dx0, r_s_dy0;
    logic               en_b, emit, s_done;
    logic [3:0]         pick, rem_after;
    logic               pick_i, pick_j;

    always_comb begin
        pick      = r_s_rem & (~r_s_rem + 4'd1);
        rem_after = r_s_rem & ~pick;
        pick_i    = pick[2] || pick[3];
        pick_j    = pick[1] || pick[3];
    end

    assign emit   = en_b && r_s_v;
    assign s_done = emit && (rem_after == '0);
    assign take_a = r_a3_v && (!r_s_v || s_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (take_a) begin
            r_s_v <= (ld_mask != '0);
        end else if (s_done) begin
            r_s_v <= 1'b0;
        end
        if (take_a) begin
            r_s_rem <= ld_mask;
            r_s_sx  <= ld_sx;
            r_s_sy  <= ld_sy;
            r_s_dx0 <= ld_dx0;
            r_s_dy0 <= ld_dy0;
        end else if (emit) begin
            r_s_rem <= rem_after;
        end
    end

    // pixel pipe: offsets, squared distance, root, weight
    logic               r_b1_v, r_b2_v, r_out_v;
    t_pix_tag           r_b1_tag, r_b2_tag;
    logic [MAG_W-1:0]   r_b1_mx, r_b1_my;
    logic [D2_W-1:0]    r_b2_d2;
    logic [11:0]        sel_cx, sel_cy;
    logic               sq_v;
    logic [ROOT_W-1:0]  sq_root;
    t_pix_tag           sq_tag;
    logic [ROOT_W-1:0]  wgt;
    logic [ROOT_W-1:0]  cov_sum;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic [COV_W-1:0]   r_out_cov;
    logic               r_out_last;

    assign en_b   = !r_out_v || i_m_tready;
    assign sel_cx = 12'(r_s_sx) + {11'b0, pick_i};
    assign sel_cy = 12'(r_s_sy) + {11'b0, pick_j};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_b2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en_b) begin
            r_b1_v  <= r_s_v;
            r_b2_v  <= r_b1_v;
            r_out_v <= sq_v;
        end
        if (en_b) begin
            r_b1_tag.x    <= sel_cx[COORD_W-1:0];
            r_b1_tag.y    <= sel_cy[COORD_W-1:0];
            r_b1_tag.last <= (rem_after == '0);
            r_b1_mx       <= pick_i ? (MAG_W'(65536) - {1'b0, r_s_dx0}) : {1'b0, r_s_dx0};
            r_b1_my       <= pick_j ? (MAG_W'(65536) - {1'b0, r_s_dy0}) : {1'b0, r_s_dy0};
            r_b2_tag      <= r_b1_tag;
            // full-width squares, a magnitude of one needs 33 bits
            r_b2_d2       <= ({{MAG_W{1'b0}}, r_b1_mx} * {{MAG_W{1'b0}}, r_b1_mx}) +
                             ({{MAG_W{1'b0}}, r_b1_my} * {{MAG_W{1'b0}}, r_b1_my});
            r_out_x       <= sq_tag.x;
            r_out_y       <= sq_tag.y;
            r_out_cov     <= cov_sum[COV_W+7:8];
            r_out_last    <= sq_tag.last;
        end
    end

    bpas_isqrt_pipe u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_b),
        .i_valid (r_b2_v),
        .i_val   (r_b2_d2),
        .i_tag   (r_b2_tag),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    // weight one minus distance, clamped, rounded to 8 fraction bits
    assign wgt     = sq_root[ROOT_W-1] ? '0 : (ROOT_W'(65536) - sq_root);
    assign cov_sum = wgt + ROOT_W'(128);

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {3'b000, r_out_cov, r_out_y, r_out_x};
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_ser_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v |-> (r_s_rem != '0))
        else $error("serializer holds a point with no pixel left");

    a_ser_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_v && !en_b && !take_a) |=> (r_s_v && $stable(r_s_rem)))
        else $error("serializer moved during output stall");

    a_cov_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[28:20] <= 9'd256))
        else $error("coverage above full weight");
`endif

endmodule
`default_nettype wire
